// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. In synthesis both macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/bba_pkg.sv -----
package bba_pkg;

   localparam int BITMAP_BYTES_DEFAULT = 512;
   // Bytes reachable by a search, so that every reported index fits in 12 bits.
   localparam int IDX_LIMIT_BYTES      = 512;
   localparam int BITS_PER_BYTE        = 8;
   localparam int INDEX_W              = 12;
   localparam int START_W              = 9;

   typedef enum logic [1:0] {
      CMD_FIND      = 2'd0,
      CMD_MARK_USED = 2'd1,
      CMD_MARK_FREE = 2'd2,
      CMD_TEST      = 2'd3
   } command_type;

   typedef struct packed {
      command_type          command;
      logic [INDEX_W-1:0]   bit_index;
      logic                 occupy;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [INDEX_W-1:0]   result_index;
      logic                 bit_value;
   } rsp_type;

   // Position of the lowest clear bit of a byte; only meaningful when one exists.
   function automatic logic [2:0] first_zero(input logic [BITS_PER_BYTE-1:0] value);
      logic [2:0] pos;
      pos = '0;
      for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
         if (!value[i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- rtl/bitmap_block_allocator_top.sv -----
// First-fit block allocator over a free-space bitmap held in an on-chip memory of
// BITMAP_BYTES bytes, one bit per block, bit 0 of each byte first, a set bit meaning used.
// A request is taken when start is high and busy is low; every request yields exactly one
// result, shown on rsp for a single cycle while rsp_valid is high. The receiver cannot
// stall, so it must capture the result in that cycle. After reset the block sweeps the
// memory to zero, one byte per cycle, and holds busy high until the sweep is done, before
// the first request is taken. Mark, free and test requests keep busy high through a
// registered read and the evaluation of the addressed byte, then deliver the result
// from a register. A find request examines one byte at a time, each by a registered read
// and then the evaluation of that byte; the single read port of the bitmap memory sets
// this pace. A find whose start byte lies beyond the searchable range answers not-found
// in the cycle after acceptance. The search start byte is written through the csr port,
// which is always ready; it should be written only while idle.
`include "assert_macros.svh"

module bitmap_block_allocator_top #(
   parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bba_pkg::req_type              req,
   output logic                          rsp_valid,
   output bba_pkg::rsp_type              rsp,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bba_pkg::START_W-1:0]   csr_data
);

   import bba_pkg::*;

   // Memory address width; at least one bit so a one-byte bitmap still elaborates.
   localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   // The search covers bytes below both the bitmap size and the index limit.
   localparam int SCAN_BYTES = (BITMAP_BYTES < IDX_LIMIT_BYTES) ? BITMAP_BYTES
                                                                : IDX_LIMIT_BYTES;
   localparam logic [START_W:0]  SCAN_LIM  = (START_W+1)'(SCAN_BYTES);
   localparam logic [20:0]       BIT_LIM   = 21'(BITMAP_BYTES * BITS_PER_BYTE);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(BITMAP_BYTES - 1);

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_EVAL  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic [START_W-1:0]       start_byte_ff, start_byte_in;
   logic [START_W-1:0]       cur_byte_ff, cur_byte_in;
   req_type                  req_ff, req_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic [BITS_PER_BYTE-1:0] rd_data_ff;

   // The bitmap itself: one write port and one registered read port.
   logic [BITS_PER_BYTE-1:0] usage_mem [BITMAP_BYTES];

   logic                     accept;
   logic                     start_oor;
   logic                     idx_ok;
   logic [START_W:0]         next_byte;
   logic [2:0]               zero_pos;
   logic                     mem_we;
   logic [AW-1:0]            mem_wa;
   logic [BITS_PER_BYTE-1:0] mem_wd;
   logic                     mem_re;
   logic [BITS_PER_BYTE-1:0] bit_mask;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // A find whose start byte is already past the searchable range fails at once.
   assign start_oor = ({1'b0, start_byte_ff} >= SCAN_LIM);
   assign idx_ok    = ({9'd0, req_ff.bit_index} < BIT_LIM);
   assign next_byte = {1'b0, cur_byte_ff} + (START_W+1)'(1);
   assign zero_pos  = first_zero(rd_data_ff);
   assign bit_mask  = BITS_PER_BYTE'(1) << req_ff.bit_index[2:0];

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      start_byte_in = start_byte_ff;
      cur_byte_in   = cur_byte_ff;
      req_in        = req_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wa        = AW'(cur_byte_ff);
      mem_wd        = rd_data_ff;
      mem_re        = 1'b0;

      if (csr_valid && csr_ready) begin
         start_byte_in = csr_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep the bitmap to all free after reset.
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in = req;
               if (req.command == CMD_FIND) begin
                  cur_byte_in = start_byte_ff;
                  if (start_oor) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  cur_byte_in = req.bit_index[INDEX_W-1:3];
                  state_in    = S_READ;
               end
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            rsp_in   = '0;
            state_in = S_IDLE;
            unique case (req_ff.command)
               CMD_FIND: begin
                  if (rd_data_ff != '1) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.found        = 1'b1;
                     rsp_in.result_index = {cur_byte_ff, zero_pos};
                     if (req_ff.occupy) begin
                        mem_we = 1'b1;
                        mem_wd = rd_data_ff | (BITS_PER_BYTE'(1) << zero_pos);
                     end
                  end else if (next_byte < SCAN_LIM) begin
                     // Byte full: move on to the next one.
                     cur_byte_in = next_byte[START_W-1:0];
                     state_in    = S_READ;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               CMD_MARK_USED: begin
                  rsp_valid_in = 1'b1;
                  mem_we       = idx_ok;
                  mem_wd       = rd_data_ff | bit_mask;
               end
               CMD_MARK_FREE: begin
                  rsp_valid_in = 1'b1;
                  mem_we       = idx_ok;
                  mem_wd       = rd_data_ff & ~bit_mask;
               end
               CMD_TEST: begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.bit_value = idx_ok && rd_data_ff[req_ff.bit_index[2:0]];
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         start_byte_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         start_byte_ff <= start_byte_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         usage_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= usage_mem[AW'(cur_byte_ff)];
      end
   end

   // A result appears only after an evaluation or an immediate out-of-range find.
   `ASSERT_CLKD(a_rsp_source, clock, reset,
      rsp_valid_ff |-> ($past(state_ff) == S_EVAL ||
                        ($past(state_ff) == S_IDLE && $past(accept))),
      "result strobe without a finished request")
   // An accepted request that needs the memory keeps the block busy next cycle.
   `ASSERT_CLKD(a_busy_after_accept, clock, reset,
      (accept && !(req.command == CMD_FIND && start_oor)) |=> busy,
      "block not busy after taking a request")
   // The scan never reads past the searchable range.
   `ASSERT_CLKD(a_scan_in_range, clock, reset,
      (state_ff == S_READ && req_ff.command == CMD_FIND) |-> ({1'b0, cur_byte_ff} < SCAN_LIM),
      "scan beyond searchable range")
   // Only a find can report a found bit, and it lies within the searchable range.
   `ASSERT_CLKD(a_found_is_find, clock, reset,
      (rsp_valid_ff && rsp_ff.found) |-> (req_ff.command == CMD_FIND &&
         {1'b0, rsp_ff.result_index[INDEX_W-1:3]} < SCAN_LIM),
      "found flag on a non-find result")
   // A result strobe never directly follows reset being high.
   `ASSERT_ALWAYS(a_no_rsp_in_clear, clock,
      (reset || state_ff == S_CLEAR) |=> (!rsp_valid_ff || !$past(reset)),
      "result strobe during reset")

endmodule
